// File: rtl/core/eps_pkg.sv
// shared constants, register indexes and control types for the encoder position and speed block
package eps_pkg;

	localparam int COUNT_WIDTH_DEFAULT     = 32;
	localparam int SPEED_FRAC_BITS_DEFAULT = 8;

	localparam int DATA_W      = 32;
	localparam int MARK_W      = 8;
	localparam int NUM_W       = 24;
	localparam int CFG_DATA_W  = 24;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_PULSES_PER_MARK = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_NUMERATOR = 1'b1;

	localparam logic [MARK_W-1:0] RESET_PULSES_PER_MARK = 8'd10;
	localparam logic [NUM_W-1:0]  RESET_SPEED_NUMERATOR = 24'd100000;
	localparam logic [DATA_W-1:0] CLEAR_LATEST          = 32'd1000;

	typedef struct packed {
		logic update;
		logic div_start;
		logic load_out;
	} eps_cmd_t;

	typedef struct packed {
		logic div_busy;
	} eps_status_t;

endpackage

// File: rtl/core/eps_if.sv
// item channel interfaces for encoder samples and position and speed results
interface eps_in_if import eps_pkg::*; ();
	logic valid;
	logic ready;
	logic channel_a;
	logic channel_b;
	logic clear;

	modport source (output valid, output channel_a, output channel_b, output clear, input ready);
	modport sink (input valid, input channel_a, input channel_b, input clear, output ready);
endinterface

interface eps_out_if import eps_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] position;
	logic [DATA_W-1:0]        pulse_total;
	logic [DATA_W-1:0]        period_ticks;
	logic [DATA_W-1:0]        speed_fixed;
	logic                     period_zero;

	modport source (output valid, output position, output pulse_total, output period_ticks,
		output speed_fixed, output period_zero, input ready);
	modport sink (input valid, input position, input pulse_total, input period_ticks,
		input speed_fixed, input period_zero, output ready);
endinterface

// File: rtl/core/eps_ctrl.sv
// controller state machine sequencing update, division and result hand-off
module eps_ctrl import eps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        out_ready,
	output logic        out_valid,
	input  eps_status_t status,
	output eps_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_next    = state_q;
		cmd.update    = 1'b0;
		cmd.div_start = 1'b0;
		cmd.load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.update = 1'b1;
					state_next = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.div_start = 1'b1;
				state_next    = ST_DIV;
			end
			ST_DIV: begin
				if (!status.div_busy) begin
					state_next = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/core/eps_datapath.sv
// counters, time captures, restoring divider and result registers
module eps_datapath import eps_pkg::*; #(
	parameter int COUNT_WIDTH     = COUNT_WIDTH_DEFAULT,
	parameter int SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     channel_a,
	input  logic                     channel_b,
	input  logic                     clear,
	input  logic                     cfg_write,
	input  logic [CFG_INDEX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  eps_cmd_t                 cmd,
	output eps_status_t              status,
	output logic signed [DATA_W-1:0] position,
	output logic [DATA_W-1:0]        pulse_total,
	output logic [DATA_W-1:0]        period_ticks,
	output logic [DATA_W-1:0]        speed_fixed,
	output logic                     period_zero
);

	localparam int QW    = NUM_W + SPEED_FRAC_BITS;
	localparam int CNT_W = $clog2(QW + 1);

	logic [MARK_W-1:0]      ppm_q;
	logic [NUM_W-1:0]       num_q;
	logic                   prev_a_q;
	logic [COUNT_WIDTH-1:0] pos_q;
	logic [COUNT_WIDTH-1:0] pulses_q;
	logic [MARK_W-1:0]      mark_div_q;
	logic [DATA_W-1:0]      tick_q;
	logic [DATA_W-1:0]      latest_q;
	logic [DATA_W-1:0]      earlier_q;

	logic [DATA_W-1:0]      divisor_q;
	logic [DATA_W-1:0]      rem_q;
	logic [QW-1:0]          quot_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   zero_q;

	logic [MARK_W-1:0]      limit;
	logic [MARK_W-1:0]      mark_next;
	logic                   capture;
	logic                   rise;
	logic [DATA_W-1:0]      period;
	logic [DATA_W:0]        rem_shift;
	logic                   ge;
	logic [DATA_W:0]        rem_diff;
	logic                   sat;

	assign limit     = (ppm_q != '0) ? ppm_q : MARK_W'(1);
	assign mark_next = mark_div_q + MARK_W'(1);
	assign capture   = (mark_next >= limit) || (mark_next == '0);
	assign rise      = channel_a && !prev_a_q;
	assign period    = latest_q - earlier_q;

	assign rem_shift = {rem_q, quot_q[QW-1]};
	assign ge        = rem_shift >= {1'b0, divisor_q};
	assign rem_diff  = rem_shift - {1'b0, divisor_q};
	assign sat       = |(quot_q >> DATA_W);

	assign status.div_busy = (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppm_q      <= RESET_PULSES_PER_MARK;
			num_q      <= RESET_SPEED_NUMERATOR;
			prev_a_q   <= 1'b0;
			pos_q      <= '0;
			pulses_q   <= '0;
			mark_div_q <= '0;
			tick_q     <= '0;
			latest_q   <= CLEAR_LATEST;
			earlier_q  <= '0;
			cnt_q      <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_PULSES_PER_MARK: ppm_q <= cfg_data[MARK_W-1:0];
					REG_SPEED_NUMERATOR: num_q <= cfg_data[NUM_W-1:0];
					default: ;
				endcase
			end
			if (cmd.update) begin
				prev_a_q <= channel_a;
				tick_q   <= tick_q + DATA_W'(1);
				priority if (clear) begin
					pos_q      <= '0;
					pulses_q   <= '0;
					mark_div_q <= '0;
					latest_q   <= CLEAR_LATEST;
					earlier_q  <= '0;
				end else if (rise) begin
					pulses_q <= pulses_q + COUNT_WIDTH'(1);
					pos_q    <= channel_b ? pos_q - COUNT_WIDTH'(1) : pos_q + COUNT_WIDTH'(1);
					if (capture) begin
						mark_div_q <= '0;
						earlier_q  <= latest_q;
						latest_q   <= tick_q;
					end else begin
						mark_div_q <= mark_next;
					end
				end
			end
			if (cmd.div_start) begin
				cnt_q <= CNT_W'(QW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			divisor_q <= period;
			zero_q    <= (period == '0);
			rem_q     <= '0;
			quot_q    <= {num_q, {SPEED_FRAC_BITS{1'b0}}};
		end else if (cnt_q != '0) begin
			rem_q  <= ge ? rem_diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
			quot_q <= {quot_q[QW-2:0], ge};
		end
		if (cmd.load_out) begin
			position     <= signed'(DATA_W'(pos_q));
			pulse_total  <= DATA_W'(pulses_q);
			period_ticks <= divisor_q;
			speed_fixed  <= (zero_q || sat) ? '1 : DATA_W'(quot_q);
			period_zero  <= zero_q;
		end
	end

endmodule

// File: rtl/core/encoder_position_and_speed.sv
// top level of the x1 quadrature encoder position and period speed block
// Each input item is one tick with the sampled A and B lines and a clear flag; each item
// gives one result with position, pulse count, period between the last two time captures
// and speed = speed_numerator * 2^SPEED_FRAC_BITS / period, saturated to all ones. The result
// of an item comes from the restoring divider that produces one quotient bit per cycle; the
// next item is taken only once that result is loaded into an output register. The result waits
// in that output register, so the next item is taken while the previous result is still
// pending. Configuration: index 0 is pulses_per_mark, index 1 is speed_numerator; write only
// while the block is idle.
module encoder_position_and_speed import eps_pkg::*; #(
	parameter int COUNT_WIDTH     = COUNT_WIDTH_DEFAULT,
	parameter int SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	eps_in_if.sink                 item_in,
	eps_out_if.source              item_out,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	eps_cmd_t    cmd;
	eps_status_t status;

	eps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_in.valid),
		.in_ready  (item_in.ready),
		.out_ready (item_out.ready),
		.out_valid (item_out.valid),
		.status    (status),
		.cmd       (cmd)
	);

	eps_datapath #(
		.COUNT_WIDTH     (COUNT_WIDTH),
		.SPEED_FRAC_BITS (SPEED_FRAC_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.channel_a    (item_in.channel_a),
		.channel_b    (item_in.channel_b),
		.clear        (item_in.clear),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.status       (status),
		.position     (item_out.position),
		.pulse_total  (item_out.pulse_total),
		.period_ticks (item_out.period_ticks),
		.speed_fixed  (item_out.speed_fixed),
		.period_zero  (item_out.period_zero)
	);

endmodule

// File: verif/encoder_position_and_speed_test.sv
// testbench for the encoder position and speed block: scoreboard with tick predictor, driven ticks
`timescale 1ns / 1ps

module encoder_position_and_speed_test;
	import eps_pkg::*;

	typedef struct packed {
		logic signed [DATA_W-1:0] position;
		logic [DATA_W-1:0]        pulse_total;
		logic [DATA_W-1:0]        period_ticks;
		logic [DATA_W-1:0]        speed_fixed;
		logic                     period_zero;
	} encoder_reading_t;

	class encoder_scoreboard;
		bit [MARK_W-1:0]  marks_per_capture;
		bit [NUM_W-1:0]   numerator;
		bit               prev_a;
		bit [DATA_W-1:0]  position;
		bit [DATA_W-1:0]  pulses;
		bit [MARK_W-1:0]  divider;
		bit [DATA_W-1:0]  tick;
		bit [DATA_W-1:0]  latest;
		bit [DATA_W-1:0]  earlier;
		encoder_reading_t readings_due[$];
		int unsigned      failures;

		function new();
			marks_per_capture = RESET_PULSES_PER_MARK;
			numerator = RESET_SPEED_NUMERATOR;
			prev_a = 1'b0;
			tick = '0;
			restart_counts();
		endfunction

		function void restart_counts();
			position = '0;
			pulses = '0;
			divider = '0;
			latest = CLEAR_LATEST;
			earlier = '0;
		endfunction

		function void flag(string what);
			failures++;
			if (failures <= 10)
				$display("%s", what);
		endfunction

		function void advance_tick(bit a, bit b, bit clr);
			bit [DATA_W-1:0] now;
			bit [MARK_W-1:0] limit;
			bit [DATA_W-1:0] period;
			bit [63:0]       quotient;
			encoder_reading_t r;
			now = tick;
			if (clr) begin
				restart_counts();
			end else if (a && !prev_a) begin
				limit = (marks_per_capture != 0) ? marks_per_capture : MARK_W'(1);
				pulses = pulses + DATA_W'(1);
				divider = divider + MARK_W'(1);
				if (divider >= limit || divider == 0) begin
					divider = '0;
					earlier = latest;
					latest = now;
				end
				position = b ? position - DATA_W'(1) : position + DATA_W'(1);
			end
			prev_a = a;
			tick = now + DATA_W'(1);
			period = latest - earlier;
			r.position = position;
			r.pulse_total = pulses;
			r.period_ticks = period;
			if (period == 0) begin
				r.speed_fixed = '1;
				r.period_zero = 1'b1;
			end else begin
				quotient = (64'(numerator) << SPEED_FRAC_BITS_DEFAULT) / 64'(period);
				r.speed_fixed = (quotient > 64'hFFFF_FFFF) ? '1 : quotient[DATA_W-1:0];
				r.period_zero = 1'b0;
			end
			readings_due.push_back(r);
		endfunction

		function void compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
			if (got !== want)
				flag($sformatf("%s mismatch: expected %h, got %h", name, want, got));
		endfunction

		function void check_reading(encoder_reading_t got);
			encoder_reading_t want;
			if (readings_due.size() == 0) begin
				flag($sformatf("unexpected reading: position %h pulses %h", got.position,
					got.pulse_total));
				return;
			end
			want = readings_due.pop_front();
			compare_field("position", want.position, got.position);
			compare_field("pulse_total", want.pulse_total, got.pulse_total);
			compare_field("period_ticks", want.period_ticks, got.period_ticks);
			compare_field("speed_fixed", want.speed_fixed, got.speed_fixed);
			compare_field("period_zero", DATA_W'(want.period_zero), DATA_W'(got.period_zero));
		endfunction

		function int pending();
			return readings_due.size();
		endfunction
	endclass

	// {channel_a, channel_b, clear}
	localparam bit [2:0] DIRECTED_TICKS [22] = '{
		3'b000, 3'b100, 3'b110, 3'b010, 3'b110, 3'b010, 3'b110, 3'b000,
		3'b100, 3'b101, 3'b100, 3'b000, 3'b110, 3'b011, 3'b111, 3'b000,
		3'b100, 3'b010, 3'b110, 3'b000, 3'b100, 3'b000
	};

	logic clk = 1'b0;
	logic arst_n;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	eps_in_if  in_ch ();
	eps_out_if out_ch ();

	encoder_scoreboard sb = new();

	int ticks_sent = 0;
	bit quiet = 1'b0;
	int hold_cycles = 0;
	bit wave_a = 1'b0;
	bit wave_dir = 1'b0;
	int wave_hold = 0;

	encoder_position_and_speed dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_in   (in_ch),
		.item_out  (out_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int stall_left;
		stall_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				sb.check_reading('{out_ch.position, out_ch.pulse_total, out_ch.period_ticks,
					out_ch.speed_fixed, out_ch.period_zero});
			if (hold_cycles > 0) begin
				out_ch.ready <= 1'b0;
				hold_cycles--;
			end else if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 4);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_tick(input bit a, input bit b, input bit clr);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.channel_a <= a;
		in_ch.channel_b <= b;
		in_ch.clear     <= clr;
		do @(posedge clk); while (!in_ch.ready);
		sb.advance_tick(a, b, clr);
		ticks_sent++;
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_config(input bit [MARK_W-1:0] marks, input bit [NUM_W-1:0] num);
		cfg_write <= 1'b1;
		cfg_index <= REG_PULSES_PER_MARK;
		cfg_data  <= CFG_DATA_W'(marks);
		@(posedge clk);
		sb.marks_per_capture = marks;
		cfg_index <= REG_SPEED_NUMERATOR;
		cfg_data  <= CFG_DATA_W'(num);
		@(posedge clk);
		sb.numerator = num;
		cfg_write <= 1'b0;
	endtask

	// mostly clean quadrature motion with direction changes, some noise and clears
	task automatic run_random(input int stop_tick);
		int pick;
		bit a;
		bit b;
		bit clr;
		while (ticks_sent < stop_tick) begin
			pick = $urandom_range(0, 99);
			clr = 1'b0;
			if (pick < 2) begin
				clr = 1'b1;
				a = $urandom_range(0, 1);
				b = $urandom_range(0, 1);
			end else if (pick < 10) begin
				a = $urandom_range(0, 1);
				b = $urandom_range(0, 1);
			end else begin
				if (wave_hold == 0) begin
					wave_a = !wave_a;
					wave_hold = $urandom_range(0, 2);
				end else begin
					wave_hold--;
				end
				if ($urandom_range(0, 24) == 0)
					wave_dir = !wave_dir;
				a = wave_a;
				b = wave_dir;
			end
			send_tick(a, b, clr);
		end
	endtask

	initial begin
		arst_n          <= 1'b0;
		cfg_write       <= 1'b0;
		cfg_index       <= REG_PULSES_PER_MARK;
		cfg_data        <= '0;
		in_ch.valid     <= 1'b0;
		in_ch.channel_a <= 1'b0;
		in_ch.channel_b <= 1'b0;
		in_ch.clear     <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(MARK_W'(1), NUM_W'(24'hFF_FFFF));
		foreach (DIRECTED_TICKS[i])
			send_tick(DIRECTED_TICKS[i][2], DIRECTED_TICKS[i][1], DIRECTED_TICKS[i][0]);
		wait_idle();

		set_config(MARK_W'(0), NUM_W'(1));
		run_random(250);
		wait_idle();

		set_config(MARK_W'(255), NUM_W'($urandom_range(1, 24'hFF_FFFF)));
		hold_cycles = 400;
		run_random(500);
		wait_idle();

		// lowered mark count, then a clear timed so the first capture lands on tick 1000
		set_config(MARK_W'(3), RESET_SPEED_NUMERATOR);
		run_random(995);
		send_tick(1'b0, $urandom_range(0, 1), 1'b1);
		for (int k = 0; k < 3; k++) begin
			if (k != 0)
				send_tick(1'b0, $urandom_range(0, 1), 1'b0);
			send_tick(1'b1, $urandom_range(0, 1), 1'b0);
		end
		run_random(1030);
		wait_idle();

		quiet = 1'b1;
		set_config(MARK_W'(7), NUM_W'($urandom_range(1, 24'hFF_FFFF)));
		run_random(1130);
		wait_idle();
		repeat (60) @(posedge clk);

		if (sb.pending() != 0)
			sb.flag($sformatf("%0d readings never arrived", sb.pending()));
		if (sb.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: encoder_position_and_speed.f
rtl/core/eps_pkg.sv
rtl/core/eps_if.sv
rtl/core/eps_ctrl.sv
rtl/core/eps_datapath.sv
rtl/core/encoder_position_and_speed.sv
verif/encoder_position_and_speed_test.sv
